### rtl/lmrs_pkg.sv
// Shared types, codes and the control program of the LED matrix row scan driver.
package lmrs_pkg;

    localparam int MAX_ROWS_DEF      = 16;
    localparam int MAX_ROW_BYTES_DEF = 8;

    localparam int UPC_W   = 4;
    localparam int HGT_W   = 5;
    localparam int RBYTE_W = 4;
    localparam int ROW_W   = 4;
    localparam int CFG_W   = 5;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] REG_DISPLAY_ON   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_ROW_BYTES    = 2'd2;

    localparam logic [2:0] ACT_SET    = 3'd0;
    localparam logic [2:0] ACT_CLEAR  = 3'd1;
    localparam logic [2:0] ACT_TOGGLE = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_SCAN   = 3'd4;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_SHIFT = 2'd1;
    localparam logic [1:0] KIND_LATCH = 2'd2;

    // Program step addresses.
    localparam logic [UPC_W-1:0] STEP_FETCH     = 4'd0;
    localparam logic [UPC_W-1:0] STEP_DISPATCH  = 4'd1;
    localparam logic [UPC_W-1:0] STEP_PIX_ADDR  = 4'd2;
    localparam logic [UPC_W-1:0] STEP_PIX_READ  = 4'd3;
    localparam logic [UPC_W-1:0] STEP_PIX_APPLY = 4'd4;
    localparam logic [UPC_W-1:0] STEP_SCAN_ADDR = 4'd5;
    localparam logic [UPC_W-1:0] STEP_SCAN_READ = 4'd6;
    localparam logic [UPC_W-1:0] STEP_SCAN_EMIT = 4'd7;
    localparam logic [UPC_W-1:0] STEP_LATCH     = 4'd8;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH_IN,
        DP_PIX_ADDR,
        DP_READ,
        DP_PIX_APPLY,
        DP_SCAN_ADDR,
        DP_SCAN_READ,
        DP_SCAN_EMIT,
        DP_ROW_LATCH
    } dp_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_WAIT_IN,
        JMP_DISPATCH,
        JMP_LOOP
    } jmp_t;

    typedef struct packed {
        dp_op_t            op;
        jmp_t              jmp;
        logic [UPC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic stall;
        logic bcnt_zero;
        logic is_pixel;
        logic is_scan_on;
    } status_t;

    function automatic ctrl_t program_rom(input logic [UPC_W-1:0] step);
        ctrl_t cw;
        unique case (step)
            STEP_FETCH:     cw = '{op: DP_LATCH_IN,  jmp: JMP_WAIT_IN,  target: STEP_FETCH};
            STEP_DISPATCH:  cw = '{op: DP_NONE,      jmp: JMP_DISPATCH, target: STEP_SCAN_ADDR};
            STEP_PIX_ADDR:  cw = '{op: DP_PIX_ADDR,  jmp: JMP_NEXT,     target: STEP_FETCH};
            STEP_PIX_READ:  cw = '{op: DP_READ,      jmp: JMP_NEXT,     target: STEP_FETCH};
            STEP_PIX_APPLY: cw = '{op: DP_PIX_APPLY, jmp: JMP_GOTO,     target: STEP_FETCH};
            STEP_SCAN_ADDR: cw = '{op: DP_SCAN_ADDR, jmp: JMP_NEXT,     target: STEP_FETCH};
            STEP_SCAN_READ: cw = '{op: DP_SCAN_READ, jmp: JMP_NEXT,     target: STEP_FETCH};
            STEP_SCAN_EMIT: cw = '{op: DP_SCAN_EMIT, jmp: JMP_LOOP,     target: STEP_FETCH};
            STEP_LATCH:     cw = '{op: DP_ROW_LATCH, jmp: JMP_GOTO,     target: STEP_FETCH};
            default:        cw = '{op: DP_NONE,      jmp: JMP_GOTO,     target: STEP_FETCH};
        endcase
        return cw;
    endfunction

endpackage

### rtl/led_matrix_row_scan_driver.sv
// Top level of the LED matrix row scan driver.
// The block holds a one-bit-per-pixel frame store and answers set, clear, toggle, query and
// scan transfers one at a time under a small control program. A pixel transfer passes
// through five steps: accept, dispatch, address, store read and apply. A scan with the
// display on reads one byte ahead, then the single store read port delivers one shift
// byte per cycle, and the row latch result follows; a scan with the display off emits
// nothing. A stalled result output holds the program where it stands. The store needs no
// clearing pass: per-entry valid bits, cleared at reset, make unwritten bytes read as zero,
// so the block accepts transfers right after reset.
module led_matrix_row_scan_driver
#(
    parameter int MAX_ROWS      = lmrs_pkg::MAX_ROWS_DEF,
    parameter int MAX_ROW_BYTES = lmrs_pkg::MAX_ROW_BYTES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lmrs_pkg::CIDX_W-1:0] cfg_index,
    input  logic [lmrs_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // x[5:0], y[9:6], toggle_enable[10]
    input  logic [2:0]                  s_axis_tuser,  // action[2:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // shift_data[7:0], row_select[11:8],
                                                       // pixel_state[12]
    output logic [1:0]                  m_axis_tuser,  // kind[1:0]
    output logic                        m_axis_tlast
);

    lmrs_pkg::ctrl_t   ctrl;
    lmrs_pkg::status_t status;

    lmrs_useq u_useq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    lmrs_datapath
    #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_latch_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == lmrs_pkg::KIND_LATCH)) |-> m_axis_tlast)
        else $error("Row latch transfer without last.");

    a_shift_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == lmrs_pkg::KIND_SHIFT)) |-> !m_axis_tlast)
        else $error("Shift byte transfer marked last.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.stall |-> (m_axis_tvalid && !m_axis_tready))
        else $error("Program stalled while the result register could take a result.");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("New transfer accepted before the previous one was dispatched.");

endmodule

### rtl/lmrs_useq.sv
// Step counter and control program that sequence the row scan datapath.
module lmrs_useq
(
    input  logic              clk,
    input  logic              rst_n,
    input  lmrs_pkg::status_t status,
    output lmrs_pkg::ctrl_t   ctrl
);

    logic [lmrs_pkg::UPC_W-1:0] upc_reg;
    logic [lmrs_pkg::UPC_W-1:0] upc_next;
    logic [lmrs_pkg::UPC_W-1:0] upc_inc;

    assign ctrl    = lmrs_pkg::program_rom(upc_reg);
    assign upc_inc = upc_reg + 1'b1;

    always_comb
    begin
        upc_next = upc_reg;
        if (!status.stall)
        begin
            case (ctrl.jmp)
                lmrs_pkg::JMP_NEXT:
                    upc_next = upc_inc;
                lmrs_pkg::JMP_GOTO:
                    upc_next = ctrl.target;
                lmrs_pkg::JMP_WAIT_IN:
                    upc_next = status.in_fire ? upc_inc : upc_reg;
                lmrs_pkg::JMP_DISPATCH:
                begin
                    if (status.is_pixel)
                        upc_next = upc_inc;
                    else if (status.is_scan_on)
                        upc_next = ctrl.target;
                    else
                        upc_next = lmrs_pkg::STEP_FETCH;
                end
                lmrs_pkg::JMP_LOOP:
                    upc_next = status.bcnt_zero ? upc_inc : upc_reg;
                default:
                    upc_next = lmrs_pkg::STEP_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= lmrs_pkg::STEP_FETCH;
        else
            upc_reg <= upc_next;
    end

endmodule

### rtl/lmrs_datapath.sv
// Datapath of the row scan driver: settings, frame store, address unit and result register.
module lmrs_datapath
#(
    parameter int MAX_ROWS      = lmrs_pkg::MAX_ROWS_DEF,
    parameter int MAX_ROW_BYTES = lmrs_pkg::MAX_ROW_BYTES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lmrs_pkg::ctrl_t             ctrl,
    output lmrs_pkg::status_t           status,
    input  logic                        cfg_we,
    input  logic [lmrs_pkg::CIDX_W-1:0] cfg_index,
    input  logic [lmrs_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,
    input  logic [2:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int DEPTH  = MAX_ROWS * MAX_ROW_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                                display_on_reg;
    logic [lmrs_pkg::HGT_W-1:0]          height_reg;
    logic [lmrs_pkg::RBYTE_W-1:0]        rbytes_reg;
    logic [lmrs_pkg::HGT_W-1:0]          eff_h;
    logic [lmrs_pkg::RBYTE_W-1:0]        eff_rb;

    logic [2:0]                          action_reg;
    logic [5:0]                          x_reg;
    logic [lmrs_pkg::ROW_W-1:0]          y_reg;
    logic                                tog_reg;

    logic [lmrs_pkg::ROW_W-1:0]          cnt_reg;
    logic [lmrs_pkg::ROW_W-1:0]          cnt_next;
    logic [lmrs_pkg::ROW_W-1:0]          row_reg;
    logic [lmrs_pkg::ROW_W-1:0]          cur_row;
    logic [lmrs_pkg::HGT_W-1:0]          row_inc;
    logic [lmrs_pkg::HGT_W-1:0]          row_sel_full;

    logic [ADDR_W-1:0]                   addr_reg;
    logic [lmrs_pkg::RBYTE_W-1:0]        bcnt_reg;
    logic                                in_panel_reg;
    logic                                in_panel;
    logic [lmrs_pkg::ROW_W-1:0]          mul_a;
    logic [7:0]                          prod;
    logic [6:0]                          add_term;
    logic [6:0]                          addr_sum;

    logic [7:0]                          mem [DEPTH];
    logic [DEPTH-1:0]                    valid_reg;
    logic [7:0]                          rd_data_reg;
    logic                                rd_valid_reg;
    logic [7:0]                          byte_val;
    logic [7:0]                          bit_mask;
    logic [7:0]                          wr_data;
    logic                                rd_en;
    logic                                wr_en;

    logic                                emit_req;
    logic                                emit_fire;
    logic                                stall;
    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic [1:0]                          kind_reg;
    logic [7:0]                          shift_reg;
    logic [lmrs_pkg::ROW_W-1:0]          rsel_reg;
    logic                                pix_reg;
    logic                                last_reg;

    // Settings; out-of-range values are clamped on use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_on_reg <= 1'b0;
            height_reg     <= 5'd16;
            rbytes_reg     <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lmrs_pkg::REG_DISPLAY_ON:   display_on_reg <= cfg_data[0];
                lmrs_pkg::REG_PANEL_HEIGHT: height_reg     <= cfg_data;
                lmrs_pkg::REG_ROW_BYTES:    rbytes_reg     <= cfg_data[lmrs_pkg::RBYTE_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        if (height_reg == '0)
            eff_h = 5'd1;
        else if (height_reg > lmrs_pkg::HGT_W'(MAX_ROWS))
            eff_h = lmrs_pkg::HGT_W'(MAX_ROWS);
        else
            eff_h = height_reg;
        if (rbytes_reg == '0)
            eff_rb = 4'd1;
        else if (rbytes_reg > lmrs_pkg::RBYTE_W'(MAX_ROW_BYTES))
            eff_rb = lmrs_pkg::RBYTE_W'(MAX_ROW_BYTES);
        else
            eff_rb = rbytes_reg;
    end

    assign s_axis_tready = (ctrl.op == lmrs_pkg::DP_LATCH_IN);

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            action_reg <= s_axis_tuser;
            x_reg      <= s_axis_tdata[5:0];
            y_reg      <= s_axis_tdata[9:6];
            tog_reg    <= s_axis_tdata[10];
        end
    end

    // Address unit: one small multiply and an add per address step.
    assign cur_row  = ({1'b0, cnt_reg} >= eff_h) ? '0 : cnt_reg;
    assign mul_a    = (ctrl.op == lmrs_pkg::DP_SCAN_ADDR) ? cur_row : y_reg;
    assign prod     = {4'd0, mul_a} * {4'd0, eff_rb};
    assign add_term = (ctrl.op == lmrs_pkg::DP_SCAN_ADDR) ? {3'd0, eff_rb - 4'd1}
                                                          : {4'd0, x_reg[5:3]};
    assign addr_sum = prod[6:0] + add_term;
    assign in_panel = ({1'b0, y_reg} < eff_h) && ({1'b0, x_reg[5:3]} < eff_rb);

    assign row_inc      = {1'b0, row_reg} + 5'd1;
    assign cnt_next     = (row_inc >= eff_h) ? '0 : row_inc[lmrs_pkg::ROW_W-1:0];
    assign row_sel_full = eff_h - 5'd1 - {1'b0, row_reg};

    assign emit_req  = ((ctrl.op == lmrs_pkg::DP_PIX_APPLY) && (action_reg == lmrs_pkg::ACT_QUERY))
                    || (ctrl.op == lmrs_pkg::DP_SCAN_EMIT)
                    || (ctrl.op == lmrs_pkg::DP_ROW_LATCH);
    assign stall     = emit_req && m_valid_reg && !m_axis_tready;
    assign emit_fire = emit_req && !stall;

    assign rd_en = (ctrl.op == lmrs_pkg::DP_READ) || (ctrl.op == lmrs_pkg::DP_SCAN_READ)
                || ((ctrl.op == lmrs_pkg::DP_SCAN_EMIT) && !stall && (bcnt_reg != '0));
    assign wr_en = (ctrl.op == lmrs_pkg::DP_PIX_APPLY) && in_panel_reg
                && (action_reg != lmrs_pkg::ACT_QUERY);

    assign byte_val = rd_valid_reg ? rd_data_reg : 8'h00;
    assign bit_mask = 8'h01 << x_reg[2:0];

    always_comb
    begin
        case (action_reg)
            lmrs_pkg::ACT_SET:    wr_data = byte_val | bit_mask;
            lmrs_pkg::ACT_CLEAR:  wr_data = byte_val & ~bit_mask;
            lmrs_pkg::ACT_TOGGLE: wr_data = byte_val ^ (tog_reg ? bit_mask : 8'h00);
            default:              wr_data = byte_val;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.op == lmrs_pkg::DP_PIX_ADDR)
        begin
            addr_reg     <= addr_sum[ADDR_W-1:0];
            in_panel_reg <= in_panel;
        end
        else if (ctrl.op == lmrs_pkg::DP_SCAN_ADDR)
        begin
            addr_reg <= addr_sum[ADDR_W-1:0];
            row_reg  <= cur_row;
            bcnt_reg <= eff_rb;
        end
        else if (rd_en && (ctrl.op != lmrs_pkg::DP_READ))
        begin
            addr_reg <= addr_reg - 1'b1;
            bcnt_reg <= bcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_reg] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
        end
    end

    // An entry not yet written reads as zero, which matches a cleared display.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[addr_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if ((ctrl.op == lmrs_pkg::DP_ROW_LATCH) && !stall)
            cnt_reg <= cnt_next;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (emit_fire)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            kind_reg  <= lmrs_pkg::KIND_QUERY;
            shift_reg <= 8'h00;
            rsel_reg  <= '0;
            pix_reg   <= 1'b0;
            last_reg  <= 1'b1;
            if (ctrl.op == lmrs_pkg::DP_SCAN_EMIT)
            begin
                kind_reg  <= lmrs_pkg::KIND_SHIFT;
                shift_reg <= byte_val ^ 8'hFF;
                last_reg  <= 1'b0;
            end
            else if (ctrl.op == lmrs_pkg::DP_ROW_LATCH)
            begin
                kind_reg <= lmrs_pkg::KIND_LATCH;
                rsel_reg <= row_sel_full[lmrs_pkg::ROW_W-1:0];
            end
            else
            begin
                pix_reg <= in_panel_reg & byte_val[x_reg[2:0]];
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'd0, pix_reg, rsel_reg, shift_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

    assign status.in_fire    = s_axis_tvalid && s_axis_tready;
    assign status.stall      = stall;
    assign status.bcnt_zero  = (bcnt_reg == '0);
    assign status.is_pixel   = (action_reg <= lmrs_pkg::ACT_QUERY);
    assign status.is_scan_on = (action_reg == lmrs_pkg::ACT_SCAN) && display_on_reg;

endmodule

### verif/led_matrix_row_scan_driver_tb.sv
// Self-checking testbench for the LED matrix row scan driver, with a frame store predictor.
`timescale 1ns / 1ps

module led_matrix_row_scan_driver_tb;

    localparam int STORE_SIZE     = lmrs_pkg::MAX_ROWS_DEF * lmrs_pkg::MAX_ROW_BYTES_DEF;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 32;
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] shift_data;
        logic [3:0] row_select;
        logic       pixel_state;
        logic       last;
    } scan_result_t;

    class frame_scoreboard;
        logic [7:0]   pixels [0:STORE_SIZE-1];
        logic [3:0]   row_counter;
        logic         display_on;
        logic [4:0]   panel_height;
        logic [3:0]   row_bytes;
        scan_result_t expected_results[$];
        int           errors;

        function new();
            foreach (pixels[i])
            begin
                pixels[i] = 8'h00;
            end
            row_counter  = 4'd0;
            display_on   = 1'b0;
            panel_height = 5'd16;
            row_bytes    = 4'd4;
            errors       = 0;
        endfunction

        function int height_used();
            if (panel_height == 0)
                return 1;
            if (panel_height > lmrs_pkg::MAX_ROWS_DEF)
                return lmrs_pkg::MAX_ROWS_DEF;
            return panel_height;
        endfunction

        function int bytes_used();
            if (row_bytes == 0)
                return 1;
            if (row_bytes > lmrs_pkg::MAX_ROW_BYTES_DEF)
                return lmrs_pkg::MAX_ROW_BYTES_DEF;
            return row_bytes;
        endfunction

        function void write_reg(logic [lmrs_pkg::CIDX_W-1:0] idx,
                                logic [lmrs_pkg::CFG_W-1:0] val);
            case (idx)
                lmrs_pkg::REG_DISPLAY_ON:   display_on   = val[0];
                lmrs_pkg::REG_PANEL_HEIGHT: panel_height = val;
                lmrs_pkg::REG_ROW_BYTES:    row_bytes    = val[3:0];
                default:                    ;
            endcase
        endfunction

        function void take_command(logic [2:0] act, logic [5:0] px, logic [3:0] py, logic te);
            int           h;
            int           rb;
            int           row;
            int           addr;
            int           i;
            bit           on_panel;
            scan_result_t r;
            h        = height_used();
            rb       = bytes_used();
            on_panel = (py < h) && (px[5:3] < rb);
            addr     = (py * rb + px[5:3]) % STORE_SIZE;
            case (act)
                lmrs_pkg::ACT_SET:
                begin
                    if (on_panel)
                        pixels[addr][px[2:0]] = 1'b1;
                end
                lmrs_pkg::ACT_CLEAR:
                begin
                    if (on_panel)
                        pixels[addr][px[2:0]] = 1'b0;
                end
                lmrs_pkg::ACT_TOGGLE:
                begin
                    if (on_panel && te)
                        pixels[addr][px[2:0]] = ~pixels[addr][px[2:0]];
                end
                lmrs_pkg::ACT_QUERY:
                begin
                    r = '{lmrs_pkg::KIND_QUERY, 8'h00, 4'h0,
                          on_panel ? pixels[addr][px[2:0]] : 1'b0, 1'b1};
                    expected_results.push_back(r);
                end
                lmrs_pkg::ACT_SCAN:
                begin
                    if (display_on)
                    begin
                        row = row_counter;
                        if (row >= h)
                            row = 0;
                        for (i = rb; i > 0; i--)
                        begin
                            r = '{lmrs_pkg::KIND_SHIFT,
                                  ~pixels[(row * rb + i - 1) % STORE_SIZE],
                                  4'h0, 1'b0, 1'b0};
                            expected_results.push_back(r);
                        end
                        r = '{lmrs_pkg::KIND_LATCH, 8'h00, 4'(h - 1 - row), 1'b0, 1'b1};
                        expected_results.push_back(r);
                        row++;
                        if (row >= h)
                            row = 0;
                        row_counter = 4'(row);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_output(scan_result_t got);
            scan_result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: kind %0d data %h row %0d pixel %0d last %0d",
                             got.kind, got.shift_data, got.row_select, got.pixel_state,
                             got.last);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.shift_data !== want.shift_data ||
                got.row_select !== want.row_select || got.pixel_state !== want.pixel_state ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("Result mismatch: expected kind %0d data %h row %0d pixel %0d last %0d",
                             want.kind, want.shift_data, want.row_select, want.pixel_state,
                             want.last);
                    $display("    got kind %0d data %h row %0d pixel %0d last %0d",
                             got.kind, got.shift_data, got.row_select, got.pixel_state,
                             got.last);
                end
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [lmrs_pkg::CIDX_W-1:0]   cfg_index;
    logic [lmrs_pkg::CFG_W-1:0]    cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata;
    logic [2:0]                    s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [15:0]                   m_axis_tdata;
    logic [1:0]                    m_axis_tuser;
    logic                          m_axis_tlast;

    frame_scoreboard     sb = new();
    bit                  quiet_src;
    bit                  quiet_snk;
    int                  idle_cycles;

    led_matrix_row_scan_driver dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output('{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
                              m_axis_tdata[12], m_axis_tlast});
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: a random stall before each transfer, none while quiet.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = quiet_snk ? 0 : $urandom_range(0, 9);
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    task automatic write_reg(input logic [lmrs_pkg::CIDX_W-1:0] idx,
                             input logic [lmrs_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic on, input logic [4:0] height, input logic [3:0] nbytes);
        write_reg(lmrs_pkg::REG_DISPLAY_ON, {4'd0, on});
        write_reg(lmrs_pkg::REG_PANEL_HEIGHT, height);
        write_reg(lmrs_pkg::REG_ROW_BYTES, {1'b0, nbytes});
    endtask

    // Valid stays high across back-to-back transfers; it only drops for a gap.
    task automatic send_item(input logic [2:0] act, input logic [5:0] px, input logic [3:0] py,
                             input logic te);
        int gap;
        gap = quiet_src ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, te, py, px};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_command(act, px, py, te);
    endtask

    task automatic random_item();
        int         pick;
        int         h;
        int         rb;
        logic [2:0] act;
        logic [5:0] px;
        logic [3:0] py;
        h    = sb.height_used();
        rb   = sb.bytes_used();
        pick = $urandom_range(0, 99);
        if (pick < 30)
            act = lmrs_pkg::ACT_SCAN;
        else if (pick < 50)
            act = lmrs_pkg::ACT_SET;
        else if (pick < 60)
            act = lmrs_pkg::ACT_CLEAR;
        else if (pick < 75)
            act = lmrs_pkg::ACT_TOGGLE;
        else if (pick < 95)
            act = lmrs_pkg::ACT_QUERY;
        else
            act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        if ($urandom_range(0, 9) < 7)
        begin
            px = 6'($urandom_range(0, rb * 8 - 1));
            py = 4'($urandom_range(0, h - 1));
        end
        else
        begin
            px = 6'($urandom);
            py = 4'($urandom);
        end
        send_item(act, px, py, 1'($urandom_range(0, 1)));
    endtask

    // Drains all results, then leaves time for a pixel command still in flight.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int         phase;
        int         n;
        int         pick;
        logic [4:0] height;
        logic [3:0] nbytes;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        quiet_src     = 1'b0;
        quiet_snk     = 1'b0;
        idle_cycles   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: display off, sixteen rows of four bytes.
        send_item(lmrs_pkg::ACT_QUERY, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_SET, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_SET, 6'd31, 4'd15, 1'b0);
        send_item(lmrs_pkg::ACT_SET, 6'd63, 4'd15, 1'b0);
        send_item(lmrs_pkg::ACT_QUERY, 6'd63, 4'd15, 1'b1);
        send_item(lmrs_pkg::ACT_QUERY, 6'd31, 4'd15, 1'b0);
        send_item(lmrs_pkg::ACT_CLEAR, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_QUERY, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_TOGGLE, 6'd9, 4'd2, 1'b0);
        send_item(lmrs_pkg::ACT_TOGGLE, 6'd9, 4'd2, 1'b1);
        send_item(lmrs_pkg::ACT_QUERY, 6'd9, 4'd2, 1'b0);
        for (n = ACT_SPARE_FIRST; n <= ACT_SPARE_LAST; n++)
            send_item(3'(n), 6'd63, 4'd15, 1'b1);
        settle();

        configure(1'b1, 5'd16, 4'd8);
        send_item(lmrs_pkg::ACT_SET, 6'd63, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        settle();
        // The row counter now sits above the lowered height.
        configure(1'b1, 5'd1, 4'd1);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        settle();
        configure(1'b1, 5'd0, 4'd0);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        send_item(lmrs_pkg::ACT_QUERY, 6'd7, 4'd0, 1'b0);
        settle();
        configure(1'b1, 5'd31, 4'd15);
        send_item(lmrs_pkg::ACT_QUERY, 6'd63, 4'd15, 1'b0);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        settle();
        configure(1'b0, 5'd31, 4'd15);
        send_item(lmrs_pkg::ACT_SCAN, 6'd0, 4'd0, 1'b0);
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       height = 5'd1;
                1:       height = 5'd16;
                2:       height = 5'd0;
                3:       height = 5'd31;
                default: height = 5'($urandom_range(1, 16));
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:       nbytes = 4'd1;
                1:       nbytes = 4'd8;
                2:       nbytes = 4'd0;
                3:       nbytes = 4'd15;
                default: nbytes = 4'($urandom_range(1, 8));
            endcase
            configure(1'($urandom_range(0, 9) != 0), height, nbytes);
            quiet_src = ($urandom_range(0, 3) == 0);
            quiet_snk = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_ITEMS; n++)
                random_item();
            settle();
        end

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
